// ===== rtl/mrbi_pkg.sv =====
// ----------------------------------------------------------------------------
// mrbi_pkg
// Shared constants and types for the maximal rectangle block.
// ----------------------------------------------------------------------------
`default_nettype none

package mrbi_pkg;

  localparam int MAX_COLS = 1024;
  localparam int MAX_ROWS = 1024;

  localparam int COL_W   = $clog2(MAX_COLS);
  localparam int DEPTH_W = COL_W + 1;
  localparam int HGT_W   = $clog2(MAX_ROWS + 1);
  localparam int CFG_W   = 11;
  localparam int AREA_W  = 21;
  localparam int PROD_W  = HGT_W + DEPTH_W;

  localparam logic [AREA_W-1:0] AREA_LIMIT      = '1;
  localparam logic [AREA_W-1:0] AREA_MAX_LEGAL  = AREA_W'(MAX_COLS * MAX_ROWS);
  localparam logic [CFG_W-1:0]  ROW_WIDTH_RESET = CFG_W'(1024);

  typedef struct packed {
    logic [COL_W-1:0] start;
    logic [HGT_W-1:0] height;
  } bar_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HEIGHT,
    S_POP,
    S_TOP,
    S_FLUSH,
    S_DRAIN
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/maximal_rectangle_binary_image.sv =====
// Each pixel steps through IDLE, HEIGHT and POP; every bar it pops that leaves the stack
// non-empty costs a TOP state to reload the cached top from the stack memory, and a pixel
// that ends a row then pops each bar left on the stack in FLUSH, again through TOP. The last
// pixel loads its result word in DRAIN, waiting there while an earlier result word is stalled.
// A new pixel is taken only in IDLE, after the previous one is through. Reset is synchronous:
// row width returns to 1024, the image restarts; the height and stack memories are kept.
// ----------------------------------------------------------------------------
// maximal_rectangle_binary_image
// Streams a binary image in raster order and reports the largest all-ones
// rectangle, using per-column run heights and a monotonic bar stack per row.
// ----------------------------------------------------------------------------
`default_nettype none

module maximal_rectangle_binary_image (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output      logic                          in_stall,
  input  wire logic                          pixel,
  input  wire logic                          last_pixel,
  output      logic                          out_valid,
  input  wire logic                          out_stall,
  output      logic [mrbi_pkg::AREA_W-1:0]   best_area,
  input  wire logic                          cfg_valid,
  output      logic                          cfg_ready,
  input  wire logic [mrbi_pkg::CFG_W-1:0]    row_width
);

  mrbi_pkg::state_t state, state_next;

  logic [mrbi_pkg::CFG_W-1:0]   width_setting;
  logic [mrbi_pkg::CFG_W-1:0]   width_use;
  logic [mrbi_pkg::COL_W-1:0]   col;
  logic [mrbi_pkg::DEPTH_W-1:0] end_col;
  logic                         first_row;
  logic [mrbi_pkg::DEPTH_W-1:0] depth;
  logic [mrbi_pkg::DEPTH_W-1:0] depth_dec;
  mrbi_pkg::bar_t               top;
  mrbi_pkg::bar_t               stack_rd;
  logic [mrbi_pkg::HGT_W-1:0]   hgt;
  logic [mrbi_pkg::HGT_W-1:0]   hgt_rd;
  logic [mrbi_pkg::HGT_W-1:0]   h_new;
  logic [mrbi_pkg::COL_W-1:0]   start_col;
  logic                         pix;
  logic                         last;
  logic                         flushing;
  logic [mrbi_pkg::PROD_W-1:0]  cand;
  logic                         cand_valid;
  logic [mrbi_pkg::AREA_W-1:0]  cand_sat;
  logic [mrbi_pkg::AREA_W-1:0]  area;
  logic [mrbi_pkg::DEPTH_W-1:0] span;

  logic accept, pop_ok, row_end, push_room;
  logic do_pop, do_push, stack_re, heights_we, emit;

  logic [mrbi_pkg::HGT_W-1:0] heights_mem [mrbi_pkg::MAX_COLS];
  mrbi_pkg::bar_t             stack_mem   [mrbi_pkg::MAX_COLS];

  // Width register: zero acts as one, oversize values act as the column count.
  always_comb begin
    if (width_setting == '0) begin
      width_use = mrbi_pkg::CFG_W'(1);
    end else if (width_setting > mrbi_pkg::CFG_W'(mrbi_pkg::MAX_COLS)) begin
      width_use = mrbi_pkg::CFG_W'(mrbi_pkg::MAX_COLS);
    end else begin
      width_use = width_setting;
    end
  end

  assign end_col   = {1'b0, col} + mrbi_pkg::DEPTH_W'(1);
  assign depth_dec = depth - mrbi_pkg::DEPTH_W'(1);
  assign pop_ok    = (depth != '0) && (top.height >= hgt);
  assign row_end   = (mrbi_pkg::CFG_W'(end_col) >= width_use) || last;
  assign push_room = depth < mrbi_pkg::DEPTH_W'(mrbi_pkg::MAX_COLS);

  always_comb begin
    if (first_row) begin
      h_new = mrbi_pkg::HGT_W'(pix);
    end else if (pix) begin
      if (hgt_rd >= mrbi_pkg::HGT_W'(mrbi_pkg::MAX_ROWS)) begin
        h_new = mrbi_pkg::HGT_W'(mrbi_pkg::MAX_ROWS);
      end else begin
        h_new = hgt_rd + mrbi_pkg::HGT_W'(1);
      end
    end else begin
      h_new = '0;
    end
  end

  // A pop inside the row measures up to the current column; a flush includes it.
  always_comb begin
    if (state == mrbi_pkg::S_FLUSH) begin
      span = end_col - {1'b0, top.start};
    end else begin
      span = {1'b0, col} - {1'b0, top.start};
    end
  end

  assign cand_sat = (cand > mrbi_pkg::PROD_W'(mrbi_pkg::AREA_LIMIT)) ?
                    mrbi_pkg::AREA_LIMIT : cand[mrbi_pkg::AREA_W-1:0];

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      mrbi_pkg::S_IDLE: begin
        if (in_valid) state_next = mrbi_pkg::S_HEIGHT;
      end
      mrbi_pkg::S_HEIGHT: begin
        state_next = mrbi_pkg::S_POP;
      end
      mrbi_pkg::S_POP: begin
        if (pop_ok) begin
          state_next = (depth_dec != '0) ? mrbi_pkg::S_TOP : mrbi_pkg::S_POP;
        end else begin
          state_next = row_end ? mrbi_pkg::S_FLUSH : mrbi_pkg::S_IDLE;
        end
      end
      mrbi_pkg::S_TOP: begin
        state_next = flushing ? mrbi_pkg::S_FLUSH : mrbi_pkg::S_POP;
      end
      mrbi_pkg::S_FLUSH: begin
        if (depth != '0) begin
          state_next = (depth_dec != '0) ? mrbi_pkg::S_TOP : mrbi_pkg::S_FLUSH;
        end else begin
          state_next = last ? mrbi_pkg::S_DRAIN : mrbi_pkg::S_IDLE;
        end
      end
      mrbi_pkg::S_DRAIN: begin
        if (!out_valid || !out_stall) state_next = mrbi_pkg::S_IDLE;
      end
      default: begin
        state_next = mrbi_pkg::S_IDLE;
      end
    endcase
  end

  // Control strobes.
  always_comb begin
    in_stall   = (state != mrbi_pkg::S_IDLE);
    cfg_ready  = 1'b1;
    accept     = (state == mrbi_pkg::S_IDLE) && in_valid;
    heights_we = (state == mrbi_pkg::S_HEIGHT);
    do_pop     = ((state == mrbi_pkg::S_POP) && pop_ok) ||
                 ((state == mrbi_pkg::S_FLUSH) && (depth != '0));
    do_push    = (state == mrbi_pkg::S_POP) && !pop_ok;
    stack_re   = do_pop && (depth_dec != '0);
    emit       = (state == mrbi_pkg::S_DRAIN) && (!out_valid || !out_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mrbi_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (heights_we) heights_mem[col] <= h_new;
    if (accept) hgt_rd <= heights_mem[col];
  end

  // The cached top mirrors the entry at depth minus one once TOP has reloaded it after a pop.
  always_ff @(posedge clk) begin
    if (do_push && push_room) begin
      stack_mem[depth[mrbi_pkg::COL_W-1:0]] <= '{start: start_col, height: hgt};
    end
    if (stack_re) begin
      stack_rd <= stack_mem[depth[mrbi_pkg::COL_W-1:0] - mrbi_pkg::COL_W'(2)];
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      pix  <= pixel;
      last <= last_pixel;
    end
    if (state == mrbi_pkg::S_HEIGHT) begin
      hgt       <= h_new;
      start_col <= col;
    end
    if (do_pop) begin
      cand <= mrbi_pkg::PROD_W'(top.height) * mrbi_pkg::PROD_W'(span);
      if (state == mrbi_pkg::S_POP) start_col <= top.start;
    end
    if (do_push) top <= '{start: start_col, height: hgt};
    if (state == mrbi_pkg::S_TOP) top <= stack_rd;
    if (emit) best_area <= area;
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      width_setting <= mrbi_pkg::ROW_WIDTH_RESET;
      col           <= '0;
      first_row     <= 1'b1;
      depth         <= '0;
      flushing      <= 1'b0;
      cand_valid    <= 1'b0;
      area          <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) width_setting <= row_width;
      cand_valid <= do_pop;
      if (do_pop) depth <= depth_dec;
      if (do_push) begin
        if (push_room) depth <= depth + mrbi_pkg::DEPTH_W'(1);
        if (row_end) begin
          flushing <= 1'b1;
        end else begin
          col <= end_col[mrbi_pkg::COL_W-1:0];
        end
      end
      if ((state == mrbi_pkg::S_FLUSH) && (depth == '0)) begin
        col       <= '0;
        first_row <= 1'b0;
        flushing  <= 1'b0;
      end
      if (emit) begin
        // No candidate is pending here: the last one folded on the way out of the flush.
        out_valid <= 1'b1;
        first_row <= 1'b1;
        area      <= '0;
      end else begin
        if (cand_valid && (cand_sat > area)) area <= cand_sat;
        if (out_valid && !out_stall) out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/mrbi_checker.sv =====
// ----------------------------------------------------------------------------
// mrbi_checker
// Port-level checks for the maximal rectangle block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module mrbi_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          in_valid,
  input wire logic                          in_stall,
  input wire logic                          out_valid,
  input wire logic                          out_stall,
  input wire logic [mrbi_pkg::AREA_W-1:0]   best_area,
  input wire logic                          cfg_valid,
  input wire logic                          cfg_ready
);

  // A result word waiting on a stall keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(best_area))
    else $error("result word changed while stalled");

  // The block stalls its input right after taking a pixel word.
  a_in_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken on consecutive cycles");

  // No image fits a rectangle larger than the full frame.
  a_area_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> best_area <= mrbi_pkg::AREA_MAX_LEGAL)
    else $error("area beyond the frame size");

  // Reset empties the output register.
  a_reset_out: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result word survived reset");

  // The width register takes a configuration word whenever one is offered.
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("configuration port not ready");

endmodule

bind maximal_rectangle_binary_image mrbi_checker u_mrbi_checker (.*);

`default_nettype wire

// ===== tb/mrbi_area_checker.sv =====
// ----------------------------------------------------------------------------
// mrbi_area_checker
// Watches the pixel, result and row-width channels of the maximal rectangle
// block. It keeps its own run heights and bar stack, predicts the best area
// for every image, and compares each result word against the oldest
// prediction.
// ----------------------------------------------------------------------------

module mrbi_area_checker
  import mrbi_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic              pixel,
  input  logic              last_pixel,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [AREA_W-1:0] best_area,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [CFG_W-1:0]  row_width,
  input  logic              run_done,
  output int                error_count,
  output int                pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [CFG_W-1:0]  width_reg;
  logic [HGT_W-1:0]  run_height [MAX_COLS];
  bar_t              bars [MAX_COLS];
  int unsigned       bar_count;
  int unsigned       next_col;
  bit                first_row;
  logic [AREA_W-1:0] image_best;
  logic [AREA_W-1:0] expected_areas [$];
  bit                closed;

  task automatic note_mismatch(input string msg);
    $display("ERROR at %0t ns: %s", $time, msg);
    error_count++;
  endtask

  function automatic void keep_larger(input longint area);
    if (area > longint'(AREA_LIMIT)) area = longint'(AREA_LIMIT);
    if (area > longint'(image_best)) image_best = AREA_W'(area);
  endfunction

  function automatic void start_image();
    bar_count  = 0;
    next_col   = 0;
    first_row  = 1'b1;
    image_best = '0;
  endfunction

  // One accepted pixel word: update the column's run height, push it as a bar
  // after popping every bar at least as tall, and flush at the end of a row.
  function automatic void absorb_pixel(input logic pix, input logic ends_image);
    int unsigned col;
    int unsigned hgt;
    int unsigned bar_start;
    int unsigned end_col;
    int unsigned eff_width;
    col = next_col;
    if (first_row) begin
      hgt = pix;
    end else if (pix) begin
      hgt = int'(run_height[col]) + 1;
      if (hgt > MAX_ROWS) hgt = MAX_ROWS;
    end else begin
      hgt = 0;
    end
    run_height[col] = HGT_W'(hgt);

    bar_start = col;
    while (bar_count > 0 && bars[bar_count-1].height >= hgt) begin
      bar_count--;
      keep_larger(longint'(bars[bar_count].height) * longint'(col - bars[bar_count].start));
      bar_start = bars[bar_count].start;
    end
    if (bar_count < MAX_COLS) begin
      bars[bar_count].start  = COL_W'(bar_start);
      bars[bar_count].height = HGT_W'(hgt);
      bar_count++;
    end

    end_col = col + 1;
    eff_width = width_reg;
    if (eff_width < 1) eff_width = 1;
    if (eff_width > MAX_COLS) eff_width = MAX_COLS;
    if (end_col >= eff_width || ends_image) begin
      while (bar_count > 0) begin
        bar_count--;
        keep_larger(longint'(bars[bar_count].height) *
                    longint'(end_col - bars[bar_count].start));
      end
      next_col  = 0;
      first_row = 1'b0;
    end else begin
      next_col = end_col;
    end

    if (ends_image) begin
      expected_areas.insert(expected_areas.size(), image_best);
      start_image();
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      width_reg   = ROW_WIDTH_RESET;
      error_count = 0;
      closed      = 1'b0;
      expected_areas.delete();
      start_image();
    end else begin
      if (cfg_valid && cfg_ready) width_reg = row_width;
      if (out_valid && !out_stall) begin
        if (expected_areas.size() == 0) begin
          note_mismatch($sformatf("result word %0d with no image pending", best_area));
        end else if (best_area !== expected_areas[0]) begin
          note_mismatch($sformatf("best_area got %0d, want %0d", best_area,
                                  expected_areas[0]));
          void'(expected_areas.pop_front());
        end else begin
          void'(expected_areas.pop_front());
        end
      end
      if (in_valid && !in_stall) absorb_pixel(pixel, last_pixel);
      if (run_done && !closed) begin
        closed = 1'b1;
        if (expected_areas.size() != 0)
          note_mismatch($sformatf("%0d image results never arrived", expected_areas.size()));
      end
    end
    pending_count = expected_areas.size();
  end

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the maximal rectangle block: directed images that hit the
// width extremes, mid-row width changes and partial rows, then random
// images under three idle profiles.
// The checker beside the block predicts and compares every result word.
// ----------------------------------------------------------------------------

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mrbi_pkg::*;

  // Worst pixel pops a full stack, plus a full-row flush, plus margin.
  localparam int DRAIN_CYCLES   = 2 * MAX_COLS + 150;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int PHASE_ITEMS    = 290;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              pixel = 1'b0;
  logic              last_pixel = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [AREA_W-1:0] best_area;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CFG_W-1:0]  row_width = '0;
  logic              run_done = 1'b0;

  int error_count;
  int pending_count;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int cur_width = 1024;
  int quiet_cycles = 0;

  always #2 clk = ~clk;

  maximal_rectangle_binary_image u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .pixel      (pixel),
    .last_pixel (last_pixel),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .best_area  (best_area),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .row_width  (row_width)
  );

  mrbi_area_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .pixel         (pixel),
    .last_pixel    (last_pixel),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .best_area     (best_area),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .row_width     (row_width),
    .run_done      (run_done),
    .error_count   (error_count),
    .pending_count (pending_count)
  );

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Valid stays high after a word is taken so that back-to-back words need no
  // second assignment in the same step; every other path lowers it first.
  task automatic send_pixel(input logic pix, input logic ends_image);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    pixel      <= pix;
    last_pixel <= ends_image;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_width(input int w);
    settle();
    cfg_valid <= 1'b1;
    row_width <= CFG_W'(w);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    cur_width = w;
  endtask

  task automatic send_run(input int count, input int density, input bit closes);
    for (int i = 0; i < count; i++)
      send_pixel($urandom_range(99) < density, closes && (i == count - 1));
  endtask

  function automatic int width_in_use(input int w);
    if (w < 1) return 1;
    if (w > MAX_COLS) return MAX_COLS;
    return w;
  endfunction

  task automatic random_images(input int budget);
    int sent;
    int pick;
    int eff;
    int count;
    int density;
    int split;
    sent = 0;
    while (sent < budget) begin
      if ($urandom_range(99) < 35) begin
        pick = $urandom_range(99);
        if (pick < 5)       write_width(0);
        else if (pick < 10) write_width($urandom_range(1024, 2047));
        else if (pick < 22) write_width($urandom_range(17, 64));
        else                write_width($urandom_range(1, 16));
      end
      if ($urandom_range(19) == 0) settle();
      eff = width_in_use(cur_width);
      case ($urandom_range(3))
        0:       density = 15;
        1:       density = 50;
        2:       density = 80;
        default: density = 97;
      endcase
      // Wide rows stay short: only a partial first row is sent.
      if (eff > 64) begin
        count = $urandom_range(1, 40);
      end else begin
        count = eff * $urandom_range(1, 8);
        if ($urandom_range(9) == 0) count = $urandom_range(1, count);
      end
      // The last image of a phase is cut short to keep the word count on budget.
      if (count > budget - sent) count = budget - sent;
      if (eff >= 2 && count > 1 && $urandom_range(7) == 0) begin
        split = $urandom_range(1, count - 1);
        send_run(split, density, 1'b0);
        write_width($urandom_range(1, eff - 1));
        send_run(count - split, density, 1'b1);
      end else begin
        send_run(count, density, 1'b1);
      end
      sent += count;
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle_pct = 8;
    recv_idle_pct = 75;

    // Reset width: single-pixel images that end mid-row.
    send_pixel(1'b1, 1'b1);
    send_pixel(1'b0, 1'b1);

    // One column: a run broken by a clear pixel.
    write_width(1);
    send_pixel(1'b1, 1'b0);
    send_pixel(1'b1, 1'b0);
    send_pixel(1'b0, 1'b0);
    send_pixel(1'b1, 1'b1);

    // Width zero behaves as one.
    write_width(0);
    send_pixel(1'b1, 1'b0);
    send_pixel(1'b1, 1'b1);

    // Equal heights must pop and merge into one bar.
    write_width(3);
    repeat (6) send_pixel(1'b1, 1'b0);
    send_pixel(1'b0, 1'b0);
    send_pixel(1'b1, 1'b0);
    send_pixel(1'b1, 1'b1);

    // Width lowered below the column already reached ends the row early.
    write_width(4);
    repeat (3) send_pixel(1'b1, 1'b0);
    write_width(2);
    send_pixel(1'b1, 1'b0);
    send_pixel(1'b0, 1'b0);
    send_pixel(1'b1, 1'b1);

    // All width bits set: clamps to the widest row.
    write_width(2047);
    send_pixel(1'b1, 1'b0);
    send_pixel(1'b0, 1'b0);
    send_pixel(1'b1, 1'b1);

    random_images(PHASE_ITEMS);

    send_idle_pct = 75;
    recv_idle_pct = 8;
    random_images(PHASE_ITEMS);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_images(PHASE_ITEMS);

    settle();
    run_done <= 1'b1;
    repeat (2) @(posedge clk);
    if (error_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/mrbi_pkg.sv
rtl/maximal_rectangle_binary_image.sv
rtl/mrbi_checker.sv
tb/mrbi_area_checker.sv
tb/tb_top.sv
